### rtl/core/quantized_vector_norm_defines.svh
// assertion macros used by quantized_vector_norm
`ifndef QUANTIZED_VECTOR_NORM_DEFINES_SVH
`define QUANTIZED_VECTOR_NORM_DEFINES_SVH

// same-cycle implication
`define QVN_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define QVN_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/qvn_pkg.sv
package qvn_pkg;

  localparam logic REQ_TABLE = 1'b0;
  localparam logic REQ_CODE  = 1'b1;

  typedef struct packed {
    logic               req_type;
    logic [1:0]         book_a;
    logic [1:0]         book_b;
    logic [5:0]         row_index;
    logic [5:0]         col_index;
    logic signed [31:0] dot_value;
    logic [5:0]         code;
    logic signed [15:0] scale;
  } qvn_item_t;

  typedef struct packed {
    logic signed [47:0] norm_value;
    logic               saturated;
  } qvn_result_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_FINISH
  } qvn_state_t;

endpackage

### rtl/core/quantized_vector_norm.sv
// Squared norm of a vector rebuilt from additive quantization codes. A table transaction
// (req_type 0) writes one dot product into the pair table and leaves no result; writes
// with book_a above book_b, or out of range, are dropped. Code transactions (req_type 1)
// are stored one per book; the one that completes a vector of n books starts n*(n+1)/2
// table reads, one per cycle on the single read port of the table memory, followed by the
// multiply, accumulate and round steps. Input stalls during that time; a finished result
// waits in the output register without blocking new transactions, but the next vector to
// finish keeps the input stalled until that register is free.
// The table holds MAX_BOOKS*(MAX_BOOKS+1)/2 * K_MAX*K_MAX words, has no reset and must be
// written before it is read. norm_value is Q32.16, rounded half up and saturated.
`include "quantized_vector_norm_defines.svh"

module quantized_vector_norm #(
  parameter int MAX_BOOKS = 4,
  parameter int K_MAX     = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_stall,
  input  qvn_pkg::qvn_item_t   item,
  output logic                 result_valid,
  input  logic                 result_stall,
  output qvn_pkg::qvn_result_t result,
  input  logic                 num_books_we,
  input  logic [2:0]           num_books_data
);

  import qvn_pkg::*;

  localparam int PAIRS = MAX_BOOKS * (MAX_BOOKS + 1) / 2;
  localparam int DEPTH = PAIRS * K_MAX * K_MAX;
  localparam int AW    = $clog2(DEPTH);
  localparam int BW    = (MAX_BOOKS > 1) ? $clog2(MAX_BOOKS) : 1;
  localparam int NW    = $clog2(MAX_BOOKS + 1);
  localparam int PW    = (PAIRS > 1) ? $clog2(PAIRS) : 1;
  localparam int KW    = $clog2(K_MAX);
  localparam int ACC_W = 66 + PW;

  localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(1) << 27;
  localparam logic signed [ACC_W-1:0] SAT_MAX  = (ACC_W'(1) << 47) - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] SAT_MIN  = ~SAT_MAX;

  typedef logic [PW-1:0] off_tab_t [MAX_BOOKS];
  typedef logic [KW-1:0] mod_tab_t [64];

  function automatic off_tab_t build_off();
    off_tab_t t;
    for (int a = 0; a < MAX_BOOKS; a++) begin
      t[a] = PW'(a * MAX_BOOKS - (a * (a - 1)) / 2 - a);
    end
    return t;
  endfunction

  function automatic mod_tab_t build_mod();
    mod_tab_t t;
    for (int i = 0; i < 64; i++) begin
      t[i] = KW'(i % K_MAX);
    end
    return t;
  endfunction

  localparam off_tab_t ROW_OFF  = build_off();
  localparam mod_tab_t CODE_MOD = build_mod();

  function automatic logic [AW-1:0] addr_of(logic [PW-1:0] p, logic [KW-1:0] r,
                                            logic [KW-1:0] c);
    return (AW'(p) * AW'(K_MAX) + AW'(c)) * AW'(K_MAX) + AW'(r);
  endfunction

  qvn_state_t state, state_next;

  logic [2:0]  num_books;
  logic [2:0]  code_count;
  logic [2:0]  count_next;
  logic [NW-1:0] eff_n;
  logic [NW-1:0] n_run;
  logic          vec_done;
  logic          item_acc;
  logic          start_run;
  logic          issue;
  logic          load_result;

  logic [5:0]         code_store  [MAX_BOOKS];
  logic signed [15:0] scale_store [MAX_BOOKS];

  logic [BW-1:0]      m_idx;
  logic [BW-1:0]      l_idx;
  logic [5:0]         code_m_q;
  logic signed [15:0] scale_m_q;
  logic [5:0]         code_l;
  logic signed [15:0] scale_l;
  logic [5:0]         code_m;
  logic signed [15:0] scale_m;
  logic               diag;
  logic               last_pair;

  logic          mem_we;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;
  logic [31:0]   rd_data;

  logic               v_s1, last_s1, cross_s1;
  logic signed [31:0] sp_s1;
  logic               v_s2, last_s2, cross_s2;
  logic signed [63:0] prod_s2;
  logic signed [ACC_W-1:0] prod_ext;
  logic signed [ACC_W-1:0] term;
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] rnd;

  assign item_stall = (state != ST_IDLE);
  assign item_acc   = item_valid && !item_stall;

  always_comb begin
    if (num_books == 3'd0) begin
      eff_n = NW'(1);
    end else if (4'(num_books) > 4'(MAX_BOOKS)) begin
      eff_n = NW'(MAX_BOOKS);
    end else begin
      eff_n = NW'(num_books);
    end
  end

  assign count_next = code_count + 3'd1;
  assign vec_done   = 4'(count_next) >= 4'(eff_n);

  // table write
  assign mem_we = item_acc && (item.req_type == REQ_TABLE)
                  && (item.book_a <= item.book_b)
                  && (32'(item.book_b) < MAX_BOOKS)
                  && (32'(item.row_index) < K_MAX)
                  && (32'(item.col_index) < K_MAX);
  assign wr_addr = addr_of(ROW_OFF[BW'(item.book_a)] + PW'(item.book_b),
                           KW'(item.row_index), KW'(item.col_index));

  // pair read
  assign code_l    = code_store[l_idx];
  assign scale_l   = scale_store[l_idx];
  assign diag      = (l_idx == m_idx);
  assign code_m    = diag ? code_l : code_m_q;
  assign scale_m   = diag ? scale_l : scale_m_q;
  assign rd_addr   = addr_of(ROW_OFF[m_idx] + PW'(l_idx), CODE_MOD[code_m], CODE_MOD[code_l]);
  assign last_pair = (NW'(m_idx) == n_run - NW'(1)) && (NW'(l_idx) == n_run - NW'(1));

  qvn_ram #(
    .WIDTH (32),
    .DEPTH (DEPTH)
  ) u_dot_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (wr_addr),
    .wdata (item.dot_value),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  always_comb begin
    state_next  = state;
    start_run   = 1'b0;
    issue       = 1'b0;
    load_result = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (item_acc && (item.req_type == REQ_CODE) && vec_done) begin
          start_run  = 1'b1;
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        issue = 1'b1;
        if (last_pair) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (v_s2 && last_s2) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!result_valid || !result_stall) begin
          load_result = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      num_books  <= 3'd4;
      code_count <= 3'd0;
    end else begin
      if (num_books_we) begin
        num_books <= num_books_data;
      end
      if (item_acc && (item.req_type == REQ_CODE)) begin
        code_count <= vec_done ? 3'd0 : count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_acc && (item.req_type == REQ_CODE) && (4'(code_count) < 4'(MAX_BOOKS))) begin
      code_store[BW'(code_count)]  <= item.code;
      scale_store[BW'(code_count)] <= item.scale;
    end
  end

  // pair sequencer
  always_ff @(posedge clk) begin
    if (start_run) begin
      n_run <= eff_n;
      m_idx <= '0;
      l_idx <= '0;
    end else if (issue) begin
      if (diag) begin
        code_m_q  <= code_l;
        scale_m_q <= scale_l;
      end
      if (NW'(l_idx) == n_run - NW'(1)) begin
        m_idx <= m_idx + BW'(1);
        l_idx <= m_idx + BW'(1);
      end else begin
        l_idx <= l_idx + BW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_s1 <= 1'b0;
      v_s2 <= 1'b0;
    end else begin
      v_s1 <= issue;
      v_s2 <= v_s1;
    end
  end

  always_ff @(posedge clk) begin
    last_s1  <= last_pair;
    cross_s1 <= !diag;
    sp_s1    <= 32'(scale_m) * 32'(scale_l);
    last_s2  <= last_s1;
    cross_s2 <= cross_s1;
    prod_s2  <= 64'(sp_s1) * 64'($signed(rd_data));
  end

  assign prod_ext = ACC_W'(prod_s2);
  assign term     = cross_s2 ? (prod_ext <<< 1) : prod_ext;

  always_ff @(posedge clk) begin
    if (start_run) begin
      acc <= '0;
    end else if (v_s2) begin
      acc <= acc + term;
    end
  end

  // round half up, then clamp
  assign rnd = (acc + RND_HALF) >>> 28;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load_result) begin
      result_valid <= 1'b1;
    end else if (result_valid && !result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_result) begin
      if (rnd > SAT_MAX) begin
        result.norm_value <= SAT_MAX[47:0];
        result.saturated  <= 1'b1;
      end else if (rnd < SAT_MIN) begin
        result.norm_value <= SAT_MIN[47:0];
        result.saturated  <= 1'b1;
      end else begin
        result.norm_value <= rnd[47:0];
        result.saturated  <= 1'b0;
      end
    end
  end

  `QVN_ASSERT_NEXT(a_vec_starts_run, item_acc && (item.req_type == REQ_CODE) && vec_done, state == ST_RUN, "completed vector did not start the pair sweep")
  `QVN_ASSERT_NOW(a_pair_order, state == ST_RUN, (l_idx >= m_idx) && (NW'(l_idx) < n_run), "pair indices out of order")
  `QVN_ASSERT_NEXT(a_hold_finish, (state == ST_FINISH) && result_valid && result_stall, state == ST_FINISH, "result overwritten while stalled")

endmodule

### rtl/core/qvn_ram.sv
module qvn_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
